// ===== rtl/quadrature_encoder_with_velocity_core_macros.svh =====
// Assertion macros shared by the quadrature encoder RTL.
`ifndef QUADRATURE_ENCODER_WITH_VELOCITY_CORE_MACROS_SVH
`define QUADRATURE_ENCODER_WITH_VELOCITY_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QENC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define QENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qenc_pkg.sv =====
// Package with types, constants and helpers of the quadrature encoder core.
`default_nettype none

package qenc_pkg;

  localparam int IN_W      = 40;
  localparam int OUT_W     = 120;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;
  localparam int CPR_W     = 17;
  localparam int STALL_W   = 20;
  localparam int TS_W      = 19;
  localparam int DT_W      = 34;
  localparam int NUM_W     = 51;
  localparam int VQ_W      = 34;
  localparam int DVD_W     = 67;
  localparam int DVS_W     = 33;
  localparam int QUO_W     = 33;
  localparam int REM_W     = 33;
  localparam int STEP_W    = 7;

  localparam logic [STEP_W-1:0]  CNT_STEPS   = 7'd32;
  localparam logic [STEP_W-1:0]  RATE_STEPS  = 7'd67;
  localparam logic [STEP_W-1:0]  VEL_STEPS   = 7'd34;
  localparam logic [CPR_W-1:0]   CPR_RESET   = 17'd4096;
  localparam logic [CPR_W-1:0]   CPR_MAX     = 17'd65536;
  localparam logic [STALL_W-1:0] STALL_RESET = 20'd100000;
  localparam logic [31:0]        TS_MAX      = 32'd500000;
  localparam logic [TS_W-1:0]    TS_FALLBACK = 19'd1000;
  localparam logic [19:0]        USEC_PER_S  = 20'd1000000;
  localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;
  localparam logic [31:0]        Q16_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]        Q16_MIN     = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_A_CHANGE = 2'd0,
    CMD_B_CHANGE = 2'd1,
    CMD_INDEX    = 2'd2,
    CMD_SAMPLE   = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    CFG_CPR      = 2'd0,
    CFG_INDEX_EN = 2'd1,
    CFG_STALL    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_CNT  = 2'd0,
    DIV_RATE = 2'd1,
    DIV_VEL  = 2'd2
  } div_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_SNAP_DIV,
    S_SNAP_WAIT,
    S_SNAP_MUL,
    S_SNAP_APPLY,
    S_RATE_MUL,
    S_RATE_DIV,
    S_RATE_WAIT,
    S_RATE_APPLY,
    S_STALL,
    S_VEL_MUL,
    S_VEL_DIV,
    S_VEL_WAIT,
    S_VEL_APPLY,
    S_POS_DIV,
    S_POS_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    in_load;
    logic    exec;
    logic    snap_mul;
    logic    snap_apply;
    logic    rate_mul;
    logic    rate_apply;
    logic    stall_chk;
    logic    vel_mul;
    logic    vel_apply;
    logic    div_start;
    div_op_t div_op;
    logic    out_load;
  } qenc_cmd_t;

  typedef struct packed {
    logic snap_go;
    logic is_sample;
    logic rate_go;
    logic div_busy;
    logic out_free;
  } qenc_stat_t;

  // Saturates a quotient magnitude with the given sign to signed 32 bits.
  function automatic logic [31:0] sat_q16(input logic neg, input logic [QUO_W-1:0] quo,
                                          input logic ovf);
    logic big;
    big = ovf | quo[QUO_W-1] | quo[31];
    if (neg) begin
      sat_q16 = big ? Q16_MIN : (32'd0 - quo[31:0]);
    end else begin
      sat_q16 = big ? Q16_MAX : quo[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quadrature_encoder_with_velocity_core.sv =====
// Top level of the quadrature encoder decoder with index realignment and velocity.
//
//   Channel   Direction  Payload
//   in_       input      tuser: command; tdata: pin_level, time_us
//   out_      output     tdata: position_count, position_in_rev, pulse_rate_q16,
//                               velocity_q16, index_seen
//   cfg_      input      index 0 counts_per_rev, 1 index_enable, 2 stall_timeout_us
//
// One item is worked on at a time. The serial divider yields one quotient bit per
// cycle, in 32 steps for the remainder, 67 for the rate and 34 for the velocity;
// each item ends with the remainder division; a realignment runs one before it,
// a velocity sample the rate division (if the rate updates) and the velocity one.
// rst_n is synchronous and holds in_tready low; an item is taken from the first
// cycle after it. A finished result waits in the output register while the next
// item is taken; if it is still waiting when that item ends, the block stalls.
`default_nettype none

module quadrature_encoder_with_velocity_core
  import qenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // pin_level [0], time_us [32:1]
  input  logic [CMD_W-1:0]     in_tuser,   // command [1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // position_count [31:0], position_in_rev [48:32],
                                           // pulse_rate_q16 [80:49], velocity_q16 [112:81],
                                           // index_seen [113]
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  qenc_cmd_t  cmd;
  qenc_stat_t st;

  qenc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd_o     (cmd),
    .st_i      (st)
  );

  qenc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/qenc_div.sv =====
// Serial restoring divider, one quotient bit per cycle, with quotient overflow flag.
`default_nettype none

`include "quadrature_encoder_with_velocity_core_macros.svh"

module qenc_div
  import qenc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              busy_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o,
  output logic [REM_W-1:0]  rem_o
);

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  div_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic              ovf_r;

  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign diff    = rem_sh - {1'b0, div_r};
  assign rem_nxt = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= steps_i;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= dividend_i;
      div_r <= divisor_i;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
    end
  end

  assign busy_o = busy_r;
  assign quo_o  = quo_r;
  assign ovf_o  = ovf_r;
  assign rem_o  = rem_r;

  `QENC_ASSERT_NEXT(a_div_start_busy, start_i, busy_r, "divider did not start")
  `QENC_ASSERT_IMPL(a_div_rem_below, busy_r, rem_r < div_r, "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/qenc_dp.sv =====
// Datapath: configuration, encoder state, rate and velocity arithmetic, output register.
`default_nettype none

module qenc_dp
  import qenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CMD_W-1:0]     in_tuser,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  qenc_cmd_t            cmd_i,
  output qenc_stat_t           st_o,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [OUT_W-1:0]     out_tdata
);

  logic [CPR_W-1:0]   cpr_r;
  logic               idx_en_r;
  logic [STALL_W-1:0] stall_r;

  cmd_code_t          cmd_r;
  logic               lvl_r;
  logic [31:0]        time_r;

  logic [31:0]        count_r;
  logic               lvl_a_r;
  logic               lvl_b_r;
  logic               lvl_idx_r;
  logic               idx_flag_r;
  logic [31:0]        last_edge_r;
  logic [31:0]        last_smp_time_r;
  logic [31:0]        last_since_r;
  logic [31:0]        last_smp_cnt_r;
  logic [31:0]        held_rate_r;

  logic [TS_W-1:0]    ts_r;
  logic [31:0]        th_r;
  logic [31:0]        dn_r;
  logic [DT_W-1:0]    dt_r;
  logic [NUM_W-1:0]   num_r;
  logic [31:0]        snap_prod_r;
  logic [VQ_W-1:0]    vq_r;
  logic [31:0]        vel_r;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [CPR_W-1:0]   eff_cpr;
  logic [31:0]        step_a;
  logic [31:0]        step_b;
  logic [31:0]        ts_raw;
  logic               ts_bad;
  logic [TS_W-1:0]    ts_val;
  logic [31:0]        th_val;
  logic [31:0]        dn_val;
  logic [DT_W-1:0]    dt_val;
  logic [31:0]        abs_count;
  logic [31:0]        abs_dn;
  logic [31:0]        abs_rate;
  logic [51:0]        num_full;
  logic               rnd_up;
  logic [31:0]        q_rnd;
  logic [48:0]        snap_full;
  logic [31:0]        fresh;
  logic [63:0]        vel_full;
  logic [CPR_W-1:0]   pos_in_rev;

  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [STEP_W-1:0]  div_steps;
  logic               div_busy;
  logic [QUO_W-1:0]   div_quo;
  logic               div_ovf;
  logic [REM_W-1:0]   div_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= CPR_RESET;
      idx_en_r <= 1'b0;
      stall_r  <= STALL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CPR:      cpr_r    <= cfg_wdata[CPR_W-1:0];
        CFG_INDEX_EN: idx_en_r <= cfg_wdata[0];
        CFG_STALL:    stall_r  <= cfg_wdata[STALL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cpr_r == '0) begin
      eff_cpr = CPR_W'(1);
    end else if (cpr_r > CPR_MAX) begin
      eff_cpr = CPR_MAX;
    end else begin
      eff_cpr = cpr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.in_load) begin
      cmd_r  <= cmd_code_t'(in_tuser);
      lvl_r  <= in_tdata[0];
      time_r <= in_tdata[32:1];
    end
  end

  assign step_a = (lvl_a_r == lvl_b_r) ? 32'd1 : 32'hFFFF_FFFF;
  assign step_b = (lvl_a_r != lvl_b_r) ? 32'd1 : 32'hFFFF_FFFF;

  assign ts_raw = time_r - last_smp_time_r;
  assign ts_bad = ts_raw[31] || (ts_raw == '0) || (ts_raw > TS_MAX);
  assign ts_val = ts_bad ? TS_FALLBACK : ts_raw[TS_W-1:0];
  assign th_val = time_r - last_edge_r;
  assign dn_val = count_r - last_smp_cnt_r;
  assign dt_val = {{(DT_W-TS_W){1'b0}}, ts_val}
                + {{(DT_W-32){last_since_r[31]}}, last_since_r}
                - {{(DT_W-32){th_val[31]}}, th_val};

  assign abs_count = count_r[31] ? (32'd0 - count_r) : count_r;
  assign abs_dn    = dn_r[31] ? (32'd0 - dn_r) : dn_r;
  assign abs_rate  = held_rate_r[31] ? (32'd0 - held_rate_r) : held_rate_r;

  assign num_full  = abs_dn * USEC_PER_S;
  assign rnd_up    = {div_rem[CPR_W-1:0], 1'b0} >= {1'b0, eff_cpr};
  assign q_rnd     = div_quo[31:0] + {31'd0, rnd_up};
  assign snap_full = q_rnd * eff_cpr;
  assign fresh     = count_r[31] ? (32'd0 - snap_prod_r) : snap_prod_r;
  assign vel_full  = abs_rate * TWO_PI_Q29;

  assign pos_in_rev = count_r[31] ? (CPR_W'(0) - div_rem[CPR_W-1:0]) : div_rem[CPR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r         <= '0;
      lvl_a_r         <= 1'b0;
      lvl_b_r         <= 1'b0;
      lvl_idx_r       <= 1'b0;
      idx_flag_r      <= 1'b0;
      last_edge_r     <= '0;
      last_smp_time_r <= '0;
      last_since_r    <= '0;
      last_smp_cnt_r  <= '0;
      held_rate_r     <= '0;
    end else if (cmd_i.exec) begin
      case (cmd_r)
        CMD_A_CHANGE: begin
          if (lvl_r != lvl_a_r) begin
            count_r     <= count_r + step_a;
            last_edge_r <= time_r;
            lvl_a_r     <= lvl_r;
          end
        end
        CMD_B_CHANGE: begin
          if (lvl_r != lvl_b_r) begin
            count_r     <= count_r + step_b;
            last_edge_r <= time_r;
            lvl_b_r     <= lvl_r;
          end
        end
        CMD_INDEX: begin
          lvl_idx_r <= lvl_r;
        end
        CMD_SAMPLE: begin
          last_smp_time_r <= time_r;
          last_since_r    <= th_val;
          last_smp_cnt_r  <= count_r;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.snap_apply) begin
      count_r        <= fresh;
      last_smp_cnt_r <= last_smp_cnt_r + fresh - count_r;
      idx_flag_r     <= 1'b1;
    end else if (cmd_i.rate_apply) begin
      held_rate_r <= sat_q16(dn_r[31], div_quo, div_ovf);
    end else if (cmd_i.stall_chk) begin
      if ($signed(th_r) > $signed({12'd0, stall_r})) begin
        held_rate_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      ts_r  <= ts_val;
      th_r  <= th_val;
      dn_r  <= dn_val;
      dt_r  <= dt_val;
      vel_r <= '0;
    end
    if (cmd_i.rate_mul) begin
      num_r <= num_full[NUM_W-1:0];
    end
    if (cmd_i.snap_mul) begin
      snap_prod_r <= snap_full[31:0];
    end
    if (cmd_i.vel_mul) begin
      vq_r <= vel_full[62:29];
    end
    if (cmd_i.vel_apply) begin
      vel_r <= sat_q16(held_rate_r[31], div_quo, div_ovf);
    end
  end

  always_comb begin
    case (cmd_i.div_op)
      DIV_RATE: begin
        div_dividend = {num_r, {(DVD_W-NUM_W){1'b0}}};
        div_divisor  = dt_r[DVS_W-1:0];
        div_steps    = RATE_STEPS;
      end
      DIV_VEL: begin
        div_dividend = {vq_r, {(DVD_W-VQ_W){1'b0}}};
        div_divisor  = {{(DVS_W-CPR_W){1'b0}}, eff_cpr};
        div_steps    = VEL_STEPS;
      end
      default: begin
        div_dividend = {abs_count, {(DVD_W-32){1'b0}}};
        div_divisor  = {{(DVS_W-CPR_W){1'b0}}, eff_cpr};
        div_steps    = CNT_STEPS;
      end
    endcase
  end

  qenc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .ovf_o      (div_ovf),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_data_r <= {6'd0, idx_flag_r, vel_r, held_rate_r, pos_in_rev, count_r};
    end
  end

  assign st_o.snap_go   = (cmd_r == CMD_INDEX) && lvl_r && !lvl_idx_r && idx_en_r;
  assign st_o.is_sample = (cmd_r == CMD_SAMPLE);
  assign st_o.rate_go   = (dn_r != '0) && ($signed({dt_r, 1'b0}) > $signed({16'd0, ts_r}));
  assign st_o.div_busy  = div_busy;
  assign st_o.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/qenc_ctrl.sv =====
// Controller state machine that sequences the datapath for each item.
`default_nettype none

`include "quadrature_encoder_with_velocity_core_macros.svh"

module qenc_ctrl
  import qenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output qenc_cmd_t  cmd_o,
  input  qenc_stat_t st_i
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st_i.snap_go) begin
          state_nxt = S_SNAP_DIV;
        end else if (st_i.is_sample) begin
          state_nxt = S_RATE_MUL;
        end else begin
          state_nxt = S_POS_DIV;
        end
      end
      S_SNAP_DIV:   state_nxt = S_SNAP_WAIT;
      S_SNAP_WAIT: begin
        if (!st_i.div_busy) begin
          state_nxt = S_SNAP_MUL;
        end
      end
      S_SNAP_MUL:   state_nxt = S_SNAP_APPLY;
      S_SNAP_APPLY: state_nxt = S_POS_DIV;
      S_RATE_MUL:   state_nxt = st_i.rate_go ? S_RATE_DIV : S_STALL;
      S_RATE_DIV:   state_nxt = S_RATE_WAIT;
      S_RATE_WAIT: begin
        if (!st_i.div_busy) begin
          state_nxt = S_RATE_APPLY;
        end
      end
      S_RATE_APPLY: state_nxt = S_STALL;
      S_STALL:      state_nxt = S_VEL_MUL;
      S_VEL_MUL:    state_nxt = S_VEL_DIV;
      S_VEL_DIV:    state_nxt = S_VEL_WAIT;
      S_VEL_WAIT: begin
        if (!st_i.div_busy) begin
          state_nxt = S_VEL_APPLY;
        end
      end
      S_VEL_APPLY:  state_nxt = S_POS_DIV;
      S_POS_DIV:    state_nxt = S_POS_WAIT;
      S_POS_WAIT: begin
        if (!st_i.div_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd_o     = '0;
    cmd_o.div_op = DIV_CNT;
    case (state_r)
      S_IDLE: begin
        in_tready     = rst_n;
        cmd_o.in_load = in_tvalid && rst_n;
      end
      S_EXEC:       cmd_o.exec = 1'b1;
      S_SNAP_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_CNT;
      end
      S_SNAP_MUL:   cmd_o.snap_mul = 1'b1;
      S_SNAP_APPLY: cmd_o.snap_apply = 1'b1;
      S_RATE_MUL:   cmd_o.rate_mul = 1'b1;
      S_RATE_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RATE;
      end
      S_RATE_APPLY: cmd_o.rate_apply = 1'b1;
      S_STALL:      cmd_o.stall_chk = 1'b1;
      S_VEL_MUL:    cmd_o.vel_mul = 1'b1;
      S_VEL_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_VEL;
      end
      S_VEL_APPLY:  cmd_o.vel_apply = 1'b1;
      S_POS_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_CNT;
      end
      S_FINISH:     cmd_o.out_load = st_i.out_free;
      default: begin
      end
    endcase
  end

  `QENC_ASSERT_NEXT(a_ctrl_accept_exec, cmd_o.in_load, state_r == S_EXEC, "accepted item not executed")
  `QENC_ASSERT_IMPL(a_ctrl_load_free, cmd_o.out_load, st_i.out_free, "result loaded over a waiting item")
  `QENC_ASSERT_IMPL(a_ctrl_start_idle, cmd_o.div_start, !st_i.div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

// ===== verif/quadrature_encoder_with_velocity_core_test.sv =====
// Self-checking stream testbench for the quadrature encoder core with index and velocity.
`timescale 1ns / 1ps

module quadrature_encoder_with_velocity_core_test
  import qenc_pkg::*;
();

  localparam longint      MAX_INTERVAL_US = 500000;
  localparam longint      FALLBACK_US     = 1000;
  localparam logic [63:0] RAD_PER_REV_Q29 = 64'd3373259426;
  localparam logic [1:0]  CFG_SPARE       = 2'd3;
  localparam int          RANDOM_EVENTS   = 1900;
  localparam int          BLOCK_EVENTS    = 100;
  localparam int          SETTLE_CYCLES   = 200;
  localparam int          REPORT_LIMIT    = 10;

  typedef struct {
    cmd_code_t   cmd;
    logic        level;
    logic [31:0] stamp;
  } enc_event_t;

  typedef struct {
    logic [31:0] count;
    logic [16:0] in_rev;
    logic [31:0] rate;
    logic [31:0] vel;
    logic        seen;
  } enc_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [CMD_W-1:0]     in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  quadrature_encoder_with_velocity_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted decoder state and its registers.
  logic [16:0] rev_counts;
  logic        index_on;
  logic [19:0] stall_us;
  logic [31:0] enc_count;
  logic [31:0] last_edge_us;
  logic [31:0] last_sample_us;
  logic [31:0] since_edge_us;
  logic [31:0] sample_base;
  logic [31:0] held_rate;
  logic        pin_a;
  logic        pin_b;
  logic        pin_index;
  logic        realigned;

  enc_event_t  pending_events[$];
  enc_result_t expected_results[$];
  enc_event_t  cur_event;
  enc_result_t got;
  enc_result_t want;

  int n_queued    = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_mismatch  = 0;
  int n_samples   = 0;
  int n_snaps     = 0;
  int n_saturated = 0;
  int n_writes    = 0;
  int in_gap      = 0;
  int out_wait    = 0;
  int out_draw;
  bit in_hs       = 1'b0;
  bit out_hs      = 1'b0;
  bit in_pace     = 1'b0;
  bit out_pace    = 1'b0;
  bit gen_a       = 1'b0;
  bit gen_b       = 1'b0;
  bit gen_idx     = 1'b0;

  function automatic longint widen(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] rev_size();
    if (rev_counts == '0) return 64'd1;
    if (rev_counts > 17'd65536) return 64'd65536;
    return {47'd0, rev_counts};
  endfunction

  function automatic logic [31:0] clamp_q16(input logic neg, input logic [63:0] mag);
    if (neg && mag >= 64'h8000_0000) return Q16_MIN;
    if (!neg && mag > 64'h7FFF_FFFF) return Q16_MAX;
    return neg ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  function automatic void realign();
    logic        neg;
    logic [63:0] mag;
    logic [63:0] turns;
    logic [63:0] rest;
    logic [63:0] snapped;
    logic [31:0] fresh;
    neg   = enc_count[31];
    mag   = neg ? {32'd0, 32'd0 - enc_count} : {32'd0, enc_count};
    turns = mag / rev_size();
    rest  = mag % rev_size();
    if (2 * rest >= rev_size()) turns = turns + 1;
    snapped = turns * rev_size();
    fresh = neg ? 32'd0 - snapped[31:0] : snapped[31:0];
    sample_base = sample_base + fresh - enc_count;
    enc_count   = fresh;
    realigned   = 1'b1;
    n_snaps++;
  endfunction

  function automatic logic [31:0] take_sample(input logic [31:0] t);
    longint      span;
    longint      age;
    longint      moved;
    longint      window;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] mag;
    logic        neg;
    span  = widen(t - last_sample_us);
    age   = widen(t - last_edge_us);
    moved = widen(enc_count - sample_base);
    if (span <= 0 || span > MAX_INTERVAL_US) span = FALLBACK_US;
    window = span + widen(since_edge_us) - age;
    if (moved != 0 && 2 * window > span) begin
      num = (moved < 0) ? -moved : moved;
      num = num * 64'd1000000;
      den = window;
      quo = num / den;
      rem = num % den;
      mag = (quo >= 64'd65536) ? 64'h1_0000_0000 : (quo << 16) + (rem << 16) / den;
      held_rate = clamp_q16(moved < 0, mag);
      if (held_rate == Q16_MAX || held_rate == Q16_MIN) n_saturated++;
    end
    if (age > longint'(stall_us)) held_rate = '0;
    last_sample_us = t;
    since_edge_us  = age[31:0];
    sample_base    = enc_count;
    n_samples++;
    neg = held_rate[31];
    mag = neg ? {32'd0, 32'd0 - held_rate} : {32'd0, held_rate};
    mag = ((mag * RAD_PER_REV_Q29) / rev_size()) >> 29;
    return clamp_q16(neg, mag);
  endfunction

  function automatic enc_result_t predict_event(input enc_event_t ev);
    enc_result_t res;
    logic [31:0] vel;
    longint      rem_rev;
    vel = '0;
    case (ev.cmd)
      CMD_A_CHANGE: begin
        if (ev.level != pin_a) begin
          enc_count    = enc_count + ((pin_a == pin_b) ? 32'd1 : 32'hFFFF_FFFF);
          last_edge_us = ev.stamp;
          pin_a        = ev.level;
        end
      end
      CMD_B_CHANGE: begin
        if (ev.level != pin_b) begin
          enc_count    = enc_count + ((pin_a != pin_b) ? 32'd1 : 32'hFFFF_FFFF);
          last_edge_us = ev.stamp;
          pin_b        = ev.level;
        end
      end
      CMD_INDEX: begin
        if (ev.level && !pin_index && index_on) realign();
        pin_index = ev.level;
      end
      CMD_SAMPLE: begin
        vel = take_sample(ev.stamp);
      end
      default: ;
    endcase
    rem_rev    = widen(enc_count) % longint'(rev_size());
    res.count  = enc_count;
    res.in_rev = rem_rev[16:0];
    res.rate   = held_rate;
    res.vel    = vel;
    res.seen   = realigned;
    return res;
  endfunction

  function automatic void push_event(input cmd_code_t c, input logic l, input logic [31:0] t);
    pending_events.push_back('{c, l, t});
    n_queued++;
    case (c)
      CMD_A_CHANGE: gen_a = l;
      CMD_B_CHANGE: gen_b = l;
      CMD_INDEX:    gen_idx = l;
      default: ;
    endcase
  endfunction

  function automatic void push_step(input bit rev, input logic [31:0] t);
    if ((gen_a == gen_b) != rev) push_event(CMD_A_CHANGE, !gen_a, t);
    else push_event(CMD_B_CHANGE, !gen_b, t);
  endfunction

  function automatic int unsigned pace_us(input int speed);
    case (speed)
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(1, 400);
      default: return $urandom_range(100, 30000);
    endcase
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_hs  <= rst_n && in_tvalid && in_tready;
    out_hs <= rst_n && out_tvalid && out_tready;
    if (!rst_n) begin
      rev_counts     = CPR_RESET;
      index_on       = 1'b0;
      stall_us       = STALL_RESET;
      enc_count      = '0;
      last_edge_us   = '0;
      last_sample_us = '0;
      since_edge_us  = '0;
      sample_base    = '0;
      held_rate      = '0;
      pin_a          = 1'b0;
      pin_b          = 1'b0;
      pin_index      = 1'b0;
      realigned      = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n_writes++;
        case (cfg_index)
          CFG_CPR:      rev_counts = cfg_wdata[16:0];
          CFG_INDEX_EN: index_on = cfg_wdata[0];
          CFG_STALL:    stall_us = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[31:0], out_tdata[48:32], out_tdata[80:49], out_tdata[112:81],
                out_tdata[113]};
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_LIMIT)
            $display("unexpected item: count %h rev %h rate %h vel %h seen %b",
                     got.count, got.in_rev, got.rate, got.vel, got.seen);
        end else begin
          want = expected_results.pop_front();
          if (got.count !== want.count || got.in_rev !== want.in_rev ||
              got.rate !== want.rate || got.vel !== want.vel || got.seen !== want.seen) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT) begin
              $display("item %0d mismatch: expected count %h rev %h rate %h vel %h seen %b",
                       n_checked, want.count, want.in_rev, want.rate, want.vel, want.seen);
              $display("  actual count %h rev %h rate %h vel %h seen %b",
                       got.count, got.in_rev, got.rate, got.vel, got.seen);
            end
          end
          n_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(
          predict_event('{cmd_code_t'(in_tuser), in_tdata[0], in_tdata[32:1]}));
        n_accepted++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_hs) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (pending_events.size() != 0) begin
        cur_event = pending_events.pop_front();
        in_tuser  <= cur_event.cmd;
        in_tdata  <= {{(IN_W-33){1'b0}}, cur_event.stamp, cur_event.level};
        in_tvalid <= 1'b1;
        in_gap    <= in_pace ? $urandom_range(0, 15) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else if (out_hs) begin
      out_draw = out_pace ? $urandom_range(0, 15) : 0;
      out_tready <= (out_draw == 0);
      out_wait   <= (out_draw == 0) ? 0 : out_draw - 1;
    end else if (!out_tready) begin
      if (out_wait != 0) out_wait <= out_wait - 1;
      else out_tready <= 1'b1;
    end
  end

  initial begin
    int          first;
    int          start;
    int          roll;
    int          speed;
    bit          noisy;
    bit          backward;
    logic [31:0] now_us;
    logic [16:0] cpr_val;
    logic [19:0] stall_val;
    backward = 1'b0;
    now_us   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_reg(CFG_SPARE, 20'hFFFFF);
    @(posedge clk);
    push_event(CMD_A_CHANGE, 1'b0, 32'd0);
    push_event(CMD_A_CHANGE, 1'b1, 32'd5);
    push_event(CMD_B_CHANGE, 1'b1, 32'd9);
    push_event(CMD_SAMPLE,   1'b1, 32'd1000);
    push_event(CMD_B_CHANGE, 1'b0, 32'd1010);
    push_event(CMD_A_CHANGE, 1'b0, 32'd1020);
    push_event(CMD_B_CHANGE, 1'b1, 32'd1030);
    push_event(CMD_A_CHANGE, 1'b1, 32'd1040);
    push_event(CMD_SAMPLE,   1'b0, 32'd1500);
    push_event(CMD_SAMPLE,   1'b0, 32'd0);
    push_event(CMD_SAMPLE,   1'b1, 32'hFFFF_FFFF);
    push_event(CMD_INDEX,    1'b1, 32'hFFFF_FFFF);
    push_event(CMD_INDEX,    1'b0, 32'd0);
    drain();

    // A count of -2 on a four-count revolution sits halfway and must round to -4.
    set_reg(CFG_CPR, 20'd4);
    set_reg(CFG_INDEX_EN, 20'd1);
    set_reg(CFG_STALL, 20'd0);
    @(posedge clk);
    push_event(CMD_INDEX,    1'b1, 32'd2000);
    push_event(CMD_INDEX,    1'b1, 32'd2001);
    push_event(CMD_INDEX,    1'b0, 32'd2002);
    push_event(CMD_A_CHANGE, 1'b0, 32'd2010);
    push_event(CMD_SAMPLE,   1'b0, 32'd2020);
    push_event(CMD_INDEX,    1'b1, 32'd2030);
    drain();

    set_reg(CFG_CPR, 20'd1);
    set_reg(CFG_STALL, 20'd1000000);
    @(posedge clk);
    push_step(1'b0, 32'd3000);
    push_step(1'b0, 32'd3000);
    push_step(1'b0, 32'd3001);
    push_step(1'b0, 32'd3001);
    push_event(CMD_SAMPLE, 1'b1, 32'd3002);
    drain();
    now_us = 32'd3002;

    first = n_queued;
    while (n_queued - first < RANDOM_EVENTS) begin
      case ($urandom_range(0, 5))
        0:       cpr_val = 17'd1;
        1:       cpr_val = 17'd65536;
        2:       cpr_val = $urandom_range(0, 1) ? 17'd0 : 17'h1FFFF;
        3:       cpr_val = $urandom_range(1, 65536);
        default: cpr_val = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 6))
        0:       stall_val = 20'd1;
        1:       stall_val = 20'd1000000;
        2:       stall_val = 20'hFFFFF;
        3:       stall_val = $urandom_range(1, 1000000);
        default: stall_val = $urandom_range(2000, 200000);
      endcase
      set_reg(CFG_CPR, {3'($urandom()), cpr_val});
      set_reg(CFG_INDEX_EN, 20'($urandom()));
      set_reg(CFG_STALL, stall_val);
      @(posedge clk);
      in_pace  = $urandom_range(0, 3) != 0;
      out_pace = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) now_us = $urandom();
      else if ($urandom_range(0, 5) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 50000);
      noisy = $urandom_range(0, 5) == 0;
      speed = $urandom_range(0, 2);
      start = n_queued;
      while (n_queued - start < BLOCK_EVENTS) begin
        roll = $urandom_range(0, 99);
        if (noisy) begin
          if (roll < 50) now_us = $urandom();
          else now_us = now_us + $urandom_range(0, 100);
          push_event(cmd_code_t'($urandom_range(0, 3)), 1'($urandom()), now_us);
        end else if (roll < 14) begin
          now_us = now_us + pace_us(speed);
          push_event(CMD_SAMPLE, 1'($urandom()), now_us);
        end else if (roll < 18) begin
          push_event(CMD_INDEX, ($urandom_range(0, 4) == 0) ? gen_idx : !gen_idx, now_us);
        end else if (roll < 20) begin
          now_us = now_us + $urandom_range(20000, 1500000);
        end else if (roll < 22) begin
          now_us = now_us - $urandom_range(0, 3000);
        end else if (roll < 26) begin
          backward = !backward;
        end else if (roll < 28) begin
          speed = $urandom_range(0, 2);
        end else begin
          now_us = now_us + pace_us(speed);
          push_step(backward, now_us);
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d items checked across %0d register writes, %0d velocity samples,",
             n_checked, n_writes, n_samples);
    $display("%0d index realignments and %0d saturated rate updates",
             n_snaps, n_saturated);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("quadrature_encoder_with_velocity_core regression: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("quadrature_encoder_with_velocity_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d of %0d items accepted", n_accepted, n_queued);
    $display("quadrature_encoder_with_velocity_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qenc_pkg.sv
rtl/qenc_div.sv
rtl/qenc_dp.sv
rtl/qenc_ctrl.sv
rtl/quadrature_encoder_with_velocity_core.sv
verif/quadrature_encoder_with_velocity_core_test.sv
